@@ design/mexp_pkg.sv @@
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Widths, reset values and the request/response types of the modular
// multiplier shared by the exponentiation datapath.
// ----------------------------------------------------------------------------
package mexp_pkg;

  // Datapath width; fields are taken in their low WORD_WIDTH bits only
  localparam int WORD_WIDTH = 64;
  // Width of the fields on the ports
  localparam int FIELD_W    = 64;
  // Bit counter of the multiplier, counts 0 .. WORD_WIDTH-1
  localparam int CNT_W      = $clog2(WORD_WIDTH);

  typedef logic [WORD_WIDTH-1:0] word_t;
  typedef logic [FIELD_W-1:0]    field_t;

  localparam field_t BASE_RESET = field_t'(5);

  // Request to the modular multiplier: result = (a * b) mod m, a < m, m >= 2.
  // b may be any word; it is scanned from its most significant bit.
  typedef struct packed {
    logic  start;
    word_t a;
    word_t b;
    word_t m;
  } mul_req_t;

  typedef struct packed {
    logic  done;
    word_t result;
  } mul_rsp_t;

endpackage

@@ design/mexp_if.sv @@
// ----------------------------------------------------------------------------
// Modular exponentiation channels
// Valid/ready channels for the operand words and the result words.
// ----------------------------------------------------------------------------
interface mexp_in_if;
  logic             valid;
  logic             ready;
  mexp_pkg::field_t exponent;
  mexp_pkg::field_t modulus;

  modport source (output valid, output exponent, output modulus, input ready);
  modport sink   (input valid, input exponent, input modulus, output ready);
endinterface

interface mexp_out_if;
  logic             valid;
  logic             ready;
  mexp_pkg::field_t residue;
  logic             bad_modulus;

  modport source (output valid, output residue, output bad_modulus, input ready);
  modport sink   (input valid, input residue, input bad_modulus, output ready);
endinterface

@@ design/mexp_mulmod.sv @@
// ----------------------------------------------------------------------------
// Modular multiplier
// Radix-2 interleaved multiplication: scans b one bit per cycle from the top
// and keeps acc = (2*acc + bit*a) mod m, below m at every step.
// ----------------------------------------------------------------------------
module mexp_mulmod (
  input  logic               clk,
  input  logic               rst_n,
  input  mexp_pkg::mul_req_t req,
  output mexp_pkg::mul_rsp_t rsp
);

  localparam int W = mexp_pkg::WORD_WIDTH;

  mexp_pkg::word_t              acc_r, acc_nxt;
  mexp_pkg::word_t              a_r, a_nxt;
  mexp_pkg::word_t              m_r, m_nxt;
  mexp_pkg::word_t              sh_r, sh_nxt;
  logic [mexp_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                         busy_r, busy_nxt;
  logic                         done_r, done_nxt;

  logic [W+1:0] sum_w, m1_w, m2_w, d1_w, d2_w;

  // 2*acc + a < 3m, so one of x, x-m, x-2m is the reduced value
  always_comb begin
    sum_w = {1'b0, acc_r, 1'b0} + (sh_r[W-1] ? {2'b00, a_r} : '0);
    m1_w  = {2'b00, m_r};
    m2_w  = {1'b0, m_r, 1'b0};
    d1_w  = sum_w - m1_w;
    d2_w  = sum_w - m2_w;
  end

  always_comb begin
    acc_nxt  = acc_r;
    a_nxt    = a_r;
    m_nxt    = m_r;
    sh_nxt   = sh_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (busy_r) begin
      if (sum_w >= m2_w) begin
        acc_nxt = d2_w[W-1:0];
      end else if (sum_w >= m1_w) begin
        acc_nxt = d1_w[W-1:0];
      end else begin
        acc_nxt = sum_w[W-1:0];
      end
      sh_nxt  = {sh_r[W-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == mexp_pkg::CNT_W'(W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (req.start) begin
      acc_nxt  = '0;
      a_nxt    = req.a;
      m_nxt    = req.m;
      sh_nxt   = req.b;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    m_r   <= m_nxt;
    sh_r  <= sh_nxt;
  end

  assign rsp.done   = done_r;
  assign rsp.result = acc_r;

  a_acc_below_mod: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && cnt_r != '0 |-> acc_r < m_r)
    else $error("multiplier accumulator not reduced");

  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("multiplier started while busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r && $past(busy_r))
    else $error("multiplier done without a finished run");

endmodule

@@ design/modular_exponentiation.sv @@
// ----------------------------------------------------------------------------
// Modular exponentiation
// Raises the configured base to each word's exponent modulo its modulus.
// ----------------------------------------------------------------------------
// One word at a time: the block takes a word (exponent, modulus), computes
// base^exponent mod modulus with right-to-left square and multiply, and
// offers one result word; the next word is taken once the result is gone.
// All arithmetic runs on one bit-serial modular multiplier (WORD_WIDTH = 64
// here). A word takes one product to reduce the base, one square per bit of
// the exponent's bit length and one multiply per set bit, and each exponent
// bit passes through a check state that picks the next product. A zero
// modulus raises bad_modulus with residue 0 and a modulus of one gives 0;
// both skip the multiplier. The base register (reset 5) is written through
// cfg_we/cfg_wdata; the user must write it only while idle, as the block
// itself does not enforce this. Only the low WORD_WIDTH bits of the base and
// of each field are used.
module modular_exponentiation (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  mexp_pkg::field_t     cfg_wdata,
  mexp_in_if.sink              in_chan,
  mexp_out_if.source           out_chan
);

  localparam int W = mexp_pkg::WORD_WIDTH;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RED,
    S_CHK,
    S_MACC,
    S_SQR,
    S_OUT
  } state_t;

  state_t             state_r, state_nxt;
  mexp_pkg::field_t   base_r;
  mexp_pkg::word_t    e_r, e_nxt;
  mexp_pkg::word_t    m_r, m_nxt;
  mexp_pkg::word_t    b_r, b_nxt;
  mexp_pkg::word_t    acc_r, acc_nxt;
  mexp_pkg::word_t    res_r, res_nxt;
  logic               bad_r, bad_nxt;
  logic               out_valid_r, out_valid_nxt;
  mexp_pkg::mul_req_t req_r, req_nxt;
  mexp_pkg::mul_rsp_t rsp;
  logic               in_acc;
  mexp_pkg::word_t    in_e, in_m;

  mexp_mulmod u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req_r),
    .rsp   (rsp)
  );

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign in_e          = in_chan.exponent[W-1:0];
  assign in_m          = in_chan.modulus[W-1:0];

  always_comb begin
    state_nxt     = state_r;
    e_nxt         = e_r;
    m_nxt         = m_r;
    b_nxt         = b_r;
    acc_nxt       = acc_r;
    res_nxt       = res_r;
    bad_nxt       = bad_r;
    out_valid_nxt = out_valid_r;
    req_nxt       = req_r;
    req_nxt.start = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          e_nxt   = in_e;
          m_nxt   = in_m;
          res_nxt = '0;
          bad_nxt = (in_m == '0);
          if (in_m == '0 || in_m == mexp_pkg::word_t'(1)) begin
            out_valid_nxt = 1'b1;
            state_nxt     = S_OUT;
          end else begin
            // reduce the base: (1 * base) mod m
            req_nxt.start = 1'b1;
            req_nxt.a     = mexp_pkg::word_t'(1);
            req_nxt.b     = base_r[W-1:0];
            req_nxt.m     = in_m;
            state_nxt     = S_RED;
          end
        end
      end
      S_RED: begin
        if (rsp.done) begin
          b_nxt     = rsp.result;
          acc_nxt   = mexp_pkg::word_t'(1);
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        req_nxt.m = m_r;
        if (e_r == '0) begin
          res_nxt       = acc_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_OUT;
        end else if (e_r[0]) begin
          req_nxt.start = 1'b1;
          req_nxt.a     = acc_r;
          req_nxt.b     = b_r;
          state_nxt     = S_MACC;
        end else begin
          req_nxt.start = 1'b1;
          req_nxt.a     = b_r;
          req_nxt.b     = b_r;
          state_nxt     = S_SQR;
        end
      end
      S_MACC: begin
        if (rsp.done) begin
          acc_nxt       = rsp.result;
          req_nxt.start = 1'b1;
          req_nxt.a     = b_r;
          req_nxt.b     = b_r;
          state_nxt     = S_SQR;
        end
      end
      S_SQR: begin
        if (rsp.done) begin
          b_nxt     = rsp.result;
          e_nxt     = {1'b0, e_r[W-1:1]};
          state_nxt = S_CHK;
        end
      end
      S_OUT: begin
        // hold the word until the sink takes it
        if (out_chan.ready) begin
          out_valid_nxt = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
        state_nxt     = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      req_r.start   <= 1'b0;
      base_r        <= mexp_pkg::BASE_RESET;
    end else begin
      state_r       <= state_nxt;
      out_valid_r   <= out_valid_nxt;
      req_r.start   <= req_nxt.start;
      if (cfg_we) begin
        base_r <= cfg_wdata;
      end
    end
    req_r.a <= req_nxt.a;
    req_r.b <= req_nxt.b;
    req_r.m <= req_nxt.m;
    e_r     <= e_nxt;
    m_r     <= m_nxt;
    b_r     <= b_nxt;
    acc_r   <= acc_nxt;
    res_r   <= res_nxt;
    bad_r   <= bad_nxt;
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.residue     = mexp_pkg::field_t'(res_r);
  assign out_chan.bad_modulus = bad_r;

  a_bad_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && bad_r |-> res_r == '0)
    else $error("bad modulus with nonzero residue");

  a_residue_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !bad_r |-> res_r < m_r)
    else $error("residue not below modulus");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_chan.ready)
    else $error("second word taken while busy");

  a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |-> state_r == S_RED || state_r == S_MACC || state_r == S_SQR)
    else $error("multiplier result with nobody waiting");

endmodule
